/* rtl/pntm_pkg.sv */
// Package for the peer neighbor table manager: table size, derived widths,
// entry status, command and action codes. No dependencies.
`default_nettype none

package pntm_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned ID_W = 64;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TGT_W = 4;
  localparam int unsigned WORD_W = 2 * ID_W + STAMP_W;

  localparam logic [TGT_W-1:0] TARGET_RESET = 4'd5;

  typedef logic [1:0] status_t;
  typedef logic [1:0] cmd_t;
  typedef logic [1:0] action_t;

  localparam status_t ST_FREE  = 2'd0;
  localparam status_t ST_CAND  = 2'd1;
  localparam status_t ST_CONN  = 2'd2;
  localparam status_t ST_NEIGH = 2'd3;

  localparam cmd_t CMD_DISCOVERED = 2'd0;
  localparam cmd_t CMD_CONNECTED  = 2'd1;
  localparam cmd_t CMD_FAILED     = 2'd2;

  localparam action_t ACT_OPEN = 2'd0;
  localparam action_t ACT_UP   = 2'd1;
  localparam action_t ACT_DOWN = 2'd2;

endpackage

`default_nettype wire

/* rtl/peer_neighbor_table_manager.sv */
// Peer neighbor table manager: peer table in a synchronous RAM, status in flops.
// Depends on pntm_pkg.
//
// Channel  | Direction | Handshake                        | Payload
// ---------+-----------+----------------------------------+------------------------------
// event    | in        | start && !busy                   | cmd_i, node_id_hi_i/lo_i
// result   | out       | res_strobe_o, one cycle, no stall| action_o, peer_id_hi_o/lo_o,
//          |           |                                  | last_o
// config   | in        | cfg_we_i                         | cfg_wdata_i (neighbor target)
//
// Each item walks the table RAM once and then updates the entry in the apply
// step. Every connection opened costs another walk of the table to find the newest
// candidate, so an item with k opens keeps busy high for k + 1 walks of the table.
// Reset clears the status flops at once; the ID RAM needs no clearing pass.
// Results are registered and leave in the cycle after they are formed.
`default_nettype none

module peer_neighbor_table_manager (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire pntm_pkg::cmd_t                 cmd_i,
  input  wire logic [pntm_pkg::ID_W-1:0]      node_id_hi_i,
  input  wire logic [pntm_pkg::ID_W-1:0]      node_id_lo_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [pntm_pkg::TGT_W-1:0]     cfg_wdata_i,
  output      logic                           res_strobe_o,
  output      pntm_pkg::action_t              action_o,
  output      logic [pntm_pkg::ID_W-1:0]      peer_id_hi_o,
  output      logic [pntm_pkg::ID_W-1:0]      peer_id_lo_o,
  output      logic                           last_o
);
  import pntm_pkg::*;

  localparam int unsigned SUM_W = (CNT_W + 1 > TGT_W) ? CNT_W + 1 : TGT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_PSCAN = 3'd3;
  localparam logic [2:0] S_PROMO = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [TGT_W-1:0]   target_q;
  logic [STAMP_W-1:0] insert_counter_q, insert_counter_d;
  logic [CNT_W-1:0]   nb_q, nb_d, cn_q, cn_d, cand_q, cand_d;

  status_t            status_q [TABLE_ENTRIES];
  logic               st_we;
  logic [IDX_W-1:0]   st_waddr;
  status_t            st_wdata;

  logic [WORD_W-1:0]  entry_mem_q [TABLE_ENTRIES];
  logic [WORD_W-1:0]  rdata_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;

  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic               rvalid_q, rvalid_d;
  logic [IDX_W-1:0]   ridx_q, ridx_d;

  cmd_t               cmd_q;
  logic [ID_W-1:0]    in_hi_q, in_lo_q;

  logic               match_found_q, match_found_d;
  logic [IDX_W-1:0]   match_idx_q, match_idx_d;
  status_t            match_stat_q, match_stat_d;
  logic               free_found_q, free_found_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic               best_found_q, best_found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [STAMP_W-1:0] best_age_q, best_age_d;
  logic [ID_W-1:0]    best_hi_q, best_hi_d, best_lo_q, best_lo_d;

  logic               strobe_q, strobe_d;
  action_t            action_q, action_d;
  logic [ID_W-1:0]    out_hi_q, out_hi_d, out_lo_q, out_lo_d;
  logic               last_q, last_d;

  logic [ID_W-1:0]    r_hi, r_lo;
  logic [STAMP_W-1:0] r_stamp, r_age;
  status_t            r_stat;
  logic               scan_done, more;
  logic [SUM_W-1:0]   active_sum;

  assign r_hi    = rdata_q[WORD_W-1 -: ID_W];
  assign r_lo    = rdata_q[STAMP_W +: ID_W];
  assign r_stamp = rdata_q[STAMP_W-1:0];
  assign r_stat  = status_q[ridx_q];
  assign r_age   = insert_counter_q - r_stamp;
  assign scan_done = (ptr_q == CNT_W'(TABLE_ENTRIES)) && !rvalid_q;

  // Promotion continues while active peers stay below target and a candidate remains.
  assign active_sum = SUM_W'(nb_d) + SUM_W'(cn_d);
  assign more = (active_sum < SUM_W'(target_q)) && (cand_d != '0);

  always_comb begin
    state_d          = state_q;
    insert_counter_d = insert_counter_q;
    nb_d             = nb_q;
    cn_d             = cn_q;
    cand_d           = cand_q;
    st_we            = 1'b0;
    st_waddr         = free_idx_q;
    st_wdata         = ST_CAND;
    mem_we           = 1'b0;
    mem_waddr        = free_idx_q;
    ptr_d            = ptr_q;
    rvalid_d         = 1'b0;
    ridx_d           = ridx_q;
    match_found_d    = match_found_q;
    match_idx_d      = match_idx_q;
    match_stat_d     = match_stat_q;
    free_found_d     = free_found_q;
    free_idx_d       = free_idx_q;
    best_found_d     = best_found_q;
    best_idx_d       = best_idx_q;
    best_age_d       = best_age_q;
    best_hi_d        = best_hi_q;
    best_lo_d        = best_lo_q;
    strobe_d         = 1'b0;
    action_d         = action_q;
    out_hi_d         = out_hi_q;
    out_lo_d         = out_lo_q;
    last_d           = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ptr_d         = '0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
          best_found_d  = 1'b0;
          state_d       = S_SCAN;
        end
      end
      S_SCAN, S_PSCAN: begin
        // Issue one RAM read a cycle; evaluate the entry read the cycle before.
        if (ptr_q != CNT_W'(TABLE_ENTRIES)) begin
          rvalid_d = 1'b1;
          ridx_d   = ptr_q[IDX_W-1:0];
          ptr_d    = ptr_q + 1'b1;
        end
        if (rvalid_q) begin
          if (r_stat != ST_FREE && r_hi == in_hi_q && r_lo == in_lo_q && !match_found_q) begin
            match_found_d = 1'b1;
            match_idx_d   = ridx_q;
            match_stat_d  = r_stat;
          end
          if (r_stat == ST_FREE && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = ridx_q;
          end
          if (r_stat == ST_CAND && (!best_found_q || r_age < best_age_q)) begin
            best_found_d = 1'b1;
            best_idx_d   = ridx_q;
            best_age_d   = r_age;
            best_hi_d    = r_hi;
            best_lo_d    = r_lo;
          end
        end
        if (scan_done) begin
          state_d = (state_q == S_SCAN) ? S_APPLY : S_PROMO;
        end
      end
      S_APPLY: begin
        out_hi_d = in_hi_q;
        out_lo_d = in_lo_q;
        priority if (cmd_q == CMD_DISCOVERED) begin
          if (!match_found_q && free_found_q) begin
            st_we            = 1'b1;
            mem_we           = 1'b1;
            insert_counter_d = insert_counter_q + 1'b1;
            cand_d           = cand_q + 1'b1;
          end
        end else if (cmd_q == CMD_CONNECTED) begin
          if (match_found_q && match_stat_q == ST_CONN) begin
            st_we    = 1'b1;
            st_waddr = match_idx_q;
            st_wdata = ST_NEIGH;
            cn_d     = cn_q - 1'b1;
            nb_d     = nb_q + 1'b1;
            strobe_d = 1'b1;
            action_d = ACT_UP;
          end
        end else if (cmd_q == CMD_FAILED) begin
          if (match_found_q) begin
            st_we    = 1'b1;
            st_waddr = match_idx_q;
            st_wdata = ST_FREE;
            unique case (match_stat_q)
              ST_NEIGH: begin
                nb_d     = nb_q - 1'b1;
                strobe_d = 1'b1;
                action_d = ACT_DOWN;
              end
              ST_CONN: cn_d = cn_q - 1'b1;
              default: cand_d = cand_q - 1'b1;
            endcase
          end
        end else begin
          // Unused code: skip the event, still run promotion.
          st_we = 1'b0;
        end
        last_d       = !more;
        ptr_d        = '0;
        best_found_d = 1'b0;
        state_d      = more ? S_PSCAN : S_IDLE;
      end
      S_PROMO: begin
        if (best_found_q) begin
          st_we    = 1'b1;
          st_waddr = best_idx_q;
          st_wdata = ST_CONN;
          cand_d   = cand_q - 1'b1;
          cn_d     = cn_q + 1'b1;
          strobe_d = 1'b1;
          action_d = ACT_OPEN;
          out_hi_d = best_hi_q;
          out_lo_d = best_lo_q;
          last_d   = !more;
          state_d  = more ? S_PSCAN : S_IDLE;
        end else begin
          cand_d  = '0;
          state_d = S_IDLE;
        end
        ptr_d        = '0;
        best_found_d = 1'b0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      target_q         <= TARGET_RESET;
      insert_counter_q <= '0;
      nb_q             <= '0;
      cn_q             <= '0;
      cand_q           <= '0;
      ptr_q            <= '0;
      rvalid_q         <= 1'b0;
      ridx_q           <= '0;
      match_found_q    <= 1'b0;
      free_found_q     <= 1'b0;
      best_found_q     <= 1'b0;
      strobe_q         <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      state_q          <= state_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      insert_counter_q <= insert_counter_d;
      nb_q             <= nb_d;
      cn_q             <= cn_d;
      cand_q           <= cand_d;
      ptr_q            <= ptr_d;
      rvalid_q         <= rvalid_d;
      ridx_q           <= ridx_d;
      match_found_q    <= match_found_d;
      free_found_q     <= free_found_d;
      best_found_q     <= best_found_d;
      strobe_q         <= strobe_d;
      if (st_we) begin
        status_q[st_waddr] <= st_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q   <= cmd_i;
      in_hi_q <= node_id_hi_i;
      in_lo_q <= node_id_lo_i;
    end
    match_idx_q  <= match_idx_d;
    match_stat_q <= match_stat_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_age_q   <= best_age_d;
    best_hi_q    <= best_hi_d;
    best_lo_q    <= best_lo_d;
    action_q     <= action_d;
    out_hi_q     <= out_hi_d;
    out_lo_q     <= out_lo_d;
    last_q       <= last_d;
  end

  // Table RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_waddr] <= {in_hi_q, in_lo_q, insert_counter_q};
    end
    rdata_q <= entry_mem_q[ptr_q[IDX_W-1:0]];
  end

  assign busy         = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign action_o     = action_q;
  assign peer_id_hi_o = out_hi_q;
  assign peer_id_lo_o = out_lo_q;
  assign last_o       = last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(nb_q) + 32'(cn_q) + 32'(cand_q)) <= TABLE_ENTRIES)
    else $error("peer counts exceed table size");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> ($past(state_q) == S_APPLY || $past(state_q) == S_PROMO))
    else $error("result strobe outside apply or promote step");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_mem_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_APPLY && st_we && st_wdata == ST_CAND))
    else $error("table RAM written outside candidate insert");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && last_o) |-> !busy)
    else $error("last result while block still busy");
`endif

endmodule

`default_nettype wire
